FILE: hdl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared widths, register indexes, reset values and the seven-segment
// digit encoding for the countdown timer.
// ----------------------------------------------------------------------------
package cdt_pkg;

    // field and register widths
    localparam int COUNT_W     = 10;
    localparam int PRESCALE_W  = 8;
    localparam int SEG_W       = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 10;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESET_IDX   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TERMINAL_IDX = 8'd1;

    // reset values
    localparam logic [COUNT_W-1:0]    PRESET_RESET   = 10'd241;
    localparam logic [PRESCALE_W-1:0] TERMINAL_RESET = 8'd71;

    // count limits and display constants
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 10'd999;
    localparam logic [COUNT_W-1:0] COUNT_HUNDRED = 10'd100;
    localparam logic [SEG_W-1:0]   POINT_BIT    = 8'd128;

    // segment pattern of one decimal digit, bit 7 left clear
    function automatic logic [SEG_W-1:0] seg_digit(input logic [3:0] digit);
        logic [SEG_W-1:0] pattern;
        case (digit)
            4'd0:    pattern = 8'd63;
            4'd1:    pattern = 8'd6;
            4'd2:    pattern = 8'd91;
            4'd3:    pattern = 8'd79;
            4'd4:    pattern = 8'd102;
            4'd5:    pattern = 8'd109;
            4'd6:    pattern = 8'd125;
            4'd7:    pattern = 8'd7;
            4'd8:    pattern = 8'd127;
            4'd9:    pattern = 8'd111;
            default: pattern = 8'd0;
        endcase
        return pattern;
    endfunction

endpackage

FILE: hdl/countdown_timer_seven_segment_top.sv
// Pipeline: a request waits in the input register and its result is stored in
// the output register once that register is free.
// Throughput: one tick per cycle unless the output stalls; the tick update
// and digit split fit in the single stage between input and output registers.
// Reset: asynchronous active low; count loads 241, terminal 71, LEDs and
// segment bytes clear, no result is pending.
// ----------------------------------------------------------------------------
// countdown_timer_seven_segment_top
// Tick-driven countdown timer with two buttons, LEDs and a two-digit
// seven-segment display encoding.
// ----------------------------------------------------------------------------
module countdown_timer_seven_segment_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_write,
    input  logic [cdt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cdt_pkg::CFG_DATA_W-1:0]  cfg_data,
    // tick channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            left_button,
    input  logic                            right_button,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cdt_pkg::SEG_W-1:0]       upper_segments,
    output logic [cdt_pkg::SEG_W-1:0]       lower_segments,
    output logic                            display_update,
    output logic                            running_led,
    output logic                            expired_led,
    output logic [cdt_pkg::COUNT_W-1:0]     count_now
);
    import cdt_pkg::*;

    // configuration registers
    logic [COUNT_W-1:0]    preset_reg;
    logic [PRESCALE_W-1:0] terminal_reg;

    // input register
    logic in_valid_reg;
    logic left_in_reg;
    logic right_in_reg;

    // timer state
    logic [PRESCALE_W-1:0] prescaler_reg;
    logic [PRESCALE_W-1:0] prescaler_next;
    logic [COUNT_W-1:0]    remaining_reg;
    logic [COUNT_W-1:0]    remaining_next;
    logic                  running_reg;
    logic                  running_next;
    logic                  left_prev_reg;
    logic                  right_prev_reg;
    logic                  expired_reg;
    logic                  expired_next;
    logic [SEG_W-1:0]      upper_reg;
    logic [SEG_W-1:0]      upper_next;
    logic [SEG_W-1:0]      lower_reg;
    logic [SEG_W-1:0]      lower_next;
    logic                  update_next;

    // output register
    logic                  out_valid_reg;
    logic                  update_reg;

    logic                  in_take;
    logic                  out_ready;
    logic                  stage_take;
    logic                  tenth;
    logic                  left_fall;
    logic                  right_fall;
    logic [COUNT_W-1:0]    preset_sat;
    logic [SEG_W-1:0]      enc_upper;
    logic [SEG_W-1:0]      enc_lower;

    // handshake: output register frees when empty or drained
    assign out_ready  = !out_valid_reg || !out_stall;
    assign stage_take = in_valid_reg && out_ready;
    assign in_stall   = in_valid_reg && !out_ready;
    assign in_take    = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preset_reg   <= PRESET_RESET;
            terminal_reg <= TERMINAL_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_PRESET_IDX)
            begin
                preset_reg <= cfg_data[COUNT_W-1:0];
            end
            else if (cfg_index == CFG_TERMINAL_IDX)
            begin
                terminal_reg <= cfg_data[PRESCALE_W-1:0];
            end
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (stage_take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            left_in_reg  <= left_button;
            right_in_reg <= right_button;
        end
    end

    // prescaler and button edges
    assign tenth      = prescaler_reg >= terminal_reg;
    assign prescaler_next = tenth ? '0 : prescaler_reg + 8'd1;
    assign left_fall  = !left_in_reg && left_prev_reg;
    assign right_fall = !right_in_reg && right_prev_reg;
    assign preset_sat = (preset_reg > COUNT_MAX) ? COUNT_MAX : preset_reg;

    // countdown, reload, toggle and zero check in model order
    always_comb
    begin
        remaining_next = remaining_reg;
        running_next   = running_reg;
        expired_next   = expired_reg;
        update_next    = 1'b0;
        if (tenth && running_reg)
        begin
            if (remaining_reg != '0)
            begin
                remaining_next = remaining_reg - 10'd1;
            end
            update_next = 1'b1;
        end
        if (left_fall)
        begin
            running_next   = 1'b0;
            remaining_next = preset_sat;
            expired_next   = 1'b0;
            update_next    = 1'b1;
        end
        if (right_fall)
        begin
            running_next = !running_next;
        end
        if (remaining_next == '0)
        begin
            running_next = 1'b0;
            expired_next = 1'b1;
        end
    end

    // display encoding of the new count
    cdt_seg_enc u_seg_enc (
        .count (remaining_next),
        .upper (enc_upper),
        .lower (enc_lower)
    );

    assign upper_next = update_next ? enc_upper : upper_reg;
    assign lower_next = update_next ? enc_lower : lower_reg;

    // timer state update, one tick per move into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescaler_reg  <= '0;
            remaining_reg  <= PRESET_RESET;
            running_reg    <= 1'b0;
            left_prev_reg  <= 1'b0;
            right_prev_reg <= 1'b0;
            expired_reg    <= 1'b0;
            upper_reg      <= '0;
            lower_reg      <= '0;
            update_reg     <= 1'b0;
        end
        else if (stage_take)
        begin
            prescaler_reg  <= prescaler_next;
            remaining_reg  <= remaining_next;
            running_reg    <= running_next;
            left_prev_reg  <= left_in_reg;
            right_prev_reg <= right_in_reg;
            expired_reg    <= expired_next;
            upper_reg      <= upper_next;
            lower_reg      <= lower_next;
            update_reg     <= update_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result ports
    assign out_valid      = out_valid_reg;
    assign upper_segments = upper_reg;
    assign lower_segments = lower_reg;
    assign display_update = update_reg;
    assign running_led    = running_reg;
    assign expired_led    = expired_reg;
    assign count_now      = remaining_reg;

endmodule

FILE: hdl/cdt_seg_enc.sv
// ----------------------------------------------------------------------------
// cdt_seg_enc
// Splits a count of at most 999 into decimal digits by reciprocal
// multiplication and encodes the two-digit display bytes.
// ----------------------------------------------------------------------------
module cdt_seg_enc (
    input  logic [cdt_pkg::COUNT_W-1:0] count,
    output logic [cdt_pkg::SEG_W-1:0]   upper,
    output logic [cdt_pkg::SEG_W-1:0]   lower
);
    import cdt_pkg::*;

    logic [17:0]        prod_tenth;
    logic [15:0]        prod_hundredth;
    logic [6:0]         quot_ten;
    logic [3:0]         quot_hundred;
    logic [COUNT_W-1:0] units_wide;
    logic [6:0]         tens_wide;
    logic [3:0]         digit_units;
    logic [3:0]         digit_tens;

    // count / 10 and count / 100, exact for counts below 1024
    assign prod_tenth     = 18'(count) * 18'd205;
    assign prod_hundredth = 16'(count) * 16'd41;
    assign quot_ten       = prod_tenth[17:11];
    assign quot_hundred   = prod_hundredth[15:12];

    // remainders give the units and tens digits
    assign units_wide  = count - 10'(quot_ten) * 10'd10;
    assign tens_wide   = quot_ten - 7'(quot_hundred) * 7'd10;
    assign digit_units = units_wide[3:0];
    assign digit_tens  = tens_wide[3:0];

    // whole seconds at 100 and up, else X.Y with point on Y, and on both at zero
    always_comb
    begin
        if (count >= COUNT_HUNDRED)
        begin
            upper = seg_digit(quot_hundred);
            lower = seg_digit(digit_tens);
        end
        else
        begin
            upper = seg_digit(digit_tens);
            if (count == '0)
            begin
                upper = upper | POINT_BIT;
            end
            lower = seg_digit(digit_units) | POINT_BIT;
        end
    end

endmodule

FILE: hdl/cdt_checker.sv
// ----------------------------------------------------------------------------
// cdt_checker
// Port-level checks on the countdown timer results, bound to the top level.
// ----------------------------------------------------------------------------
module cdt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [cdt_pkg::SEG_W-1:0]   upper_segments,
    input logic [cdt_pkg::SEG_W-1:0]   lower_segments,
    input logic                        display_update,
    input logic                        running_led,
    input logic                        expired_led,
    input logic [cdt_pkg::COUNT_W-1:0] count_now
);
    import cdt_pkg::*;

    // a stalled result request stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result request dropped while stalled");

    // an expired timer never runs
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && expired_led |-> !running_led)
        else $error("running and expired together");

    // expiry only with the count at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && expired_led |-> count_now == '0)
        else $error("expired with nonzero count");

    // the zero check stops the timer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && running_led |-> count_now != '0)
        else $error("running at zero count");

    // a fresh display at zero shows both points
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && display_update && count_now == '0
        |-> upper_segments[7] && lower_segments[7])
        else $error("zero display missing decimal points");

endmodule

bind countdown_timer_seven_segment_top cdt_checker u_cdt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .upper_segments (upper_segments),
    .lower_segments (lower_segments),
    .display_update (display_update),
    .running_led    (running_led),
    .expired_led    (expired_led),
    .count_now      (count_now)
);
